### hw/rtl/thc_pkg.sv
// shared constants, register codes and tables for the tilt compensated heading block
// no dependencies; imported by every module of the block
`default_nettype none
package thc_pkg;

  localparam int THC_FIELD_BITS    = 16;
  localparam int THC_CORDIC_STAGES = 16;

  // angle constants, q3.13 and q2.30 radians
  localparam int PI_Q13     = 25736;
  localparam int TWO_PI_Q13 = 51472;
  localparam logic signed [33:0] PI_Q30 = 34'sd3373259426;

  // q1.12 unity and half lsb
  localparam int ONE_Q12  = 4096;
  localparam int HALF_Q12 = 2048;
  localparam int CONF_W   = 13;

  // configuration register codes
  typedef enum logic [2:0] {
    REG_BIAS_X   = 3'd0,
    REG_BIAS_Y   = 3'd1,
    REG_BIAS_Z   = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_SCALE_Z  = 3'd5,
    REG_EXPECTED = 3'd6,
    REG_DECL     = 3'd7
  } cfg_reg_t;

  // confidence side flags that travel with the division lanes
  typedef struct packed {
    logic m4_zero;
    logic big_dev;
    logic vert;
  } conf_flags_t;

  // cordic arctangent table, q2.30 radians
  localparam logic signed [33:0] ATAN_Q30 [24] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133519495,
    34'sd67021687,  34'sd33543516,  34'sd16775851,  34'sd8388437,
    34'sd4194283,   34'sd2097149,   34'sd1048576,   34'sd524288,
    34'sd262144,    34'sd131072,    34'sd65536,     34'sd32768,
    34'sd16384,     34'sd8192,      34'sd4096,      34'sd2048,
    34'sd1024,      34'sd512,       34'sd256,       34'sd128
  };

endpackage
`default_nettype wire

### hw/rtl/thc_delay.sv
// register delay line with a common advance enable
// depends on thc_pkg
`default_nettype none
module thc_delay import thc_pkg::*; #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_r [N];

  // shift line
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q_o = tap_r[N-1];

endmodule
`default_nettype wire

### hw/rtl/thc_cordic_cell.sv
// one vectoring micro-rotation of the atan2 cordic chain
// depends on thc_pkg for the arctangent table
`default_nettype none
module thc_cordic_cell import thc_pkg::*; #(
  parameter int CW  = 40,
  parameter int ZW  = 34,
  parameter int IDX = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  input  wire logic signed [ZW-1:0] z_i,
  output logic signed      [CW-1:0] x_o,
  output logic signed      [CW-1:0] y_o,
  output logic signed      [ZW-1:0] z_o
);

  logic signed [CW-1:0] x_r, y_r, x_nxt, y_nxt, xs, ys;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic                 y_pos, y_neg;

  // rotate toward the x axis, accumulate the angle
  always_comb begin
    xs    = x_i >>> IDX;
    ys    = y_i >>> IDX;
    y_neg = y_i[CW-1];
    y_pos = !y_i[CW-1] && (y_i != '0);
    x_nxt = x_i;
    y_nxt = y_i;
    z_nxt = z_i;
    if (y_pos) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ZW'(ATAN_Q30[IDX]);
    end else if (y_neg) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ZW'(ATAN_Q30[IDX]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule
`default_nettype wire

### hw/rtl/thc_sqrt_cell.sv
// one result bit of the digit by digit integer square root chain
// depends on thc_pkg
`default_nettype none
module thc_sqrt_cell import thc_pkg::*; #(
  parameter int SQW = 42,
  parameter int RMW = 23,
  parameter int RTW = 21
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire logic [SQW-1:0] rad_i,
  input  wire logic [RMW-1:0] rem_i,
  input  wire logic [RTW-1:0] root_i,
  output logic      [SQW-1:0] rad_o,
  output logic      [RMW-1:0] rem_o,
  output logic      [RTW-1:0] root_o
);

  logic [SQW-1:0] rad_r;
  logic [RMW-1:0] rem_r, rem_nxt;
  logic [RTW-1:0] root_r, root_nxt;
  logic [RMW+1:0] rem_t, trial;
  logic           ge;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    rem_t    = {rem_i, rad_i[SQW-1:SQW-2]};
    trial    = (RMW+2)'({root_i, 2'b01});
    ge       = rem_t >= trial;
    rem_nxt  = ge ? RMW'(rem_t - trial) : RMW'(rem_t);
    root_nxt = {root_i[RTW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r  <= rad_i << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule
`default_nettype wire

### hw/rtl/thc_div_cell.sv
// one quotient bit of a restoring division chain with a 13 bit quotient
// depends on thc_pkg for the confidence width
`default_nettype none
module thc_div_cell import thc_pkg::*; #(
  parameter int NW  = 34,
  parameter int DVW = 21,
  parameter int K   = 12
) (
  input  wire logic              clk,
  input  wire logic              en,
  input  wire logic [NW-1:0]     rem_i,
  input  wire logic [DVW-1:0]    dv_i,
  input  wire logic [CONF_W-1:0] q_i,
  output logic      [NW-1:0]     rem_o,
  output logic      [DVW-1:0]    dv_o,
  output logic      [CONF_W-1:0] q_o
);

  logic [NW-1:0]     rem_r, shd;
  logic [DVW-1:0]    dv_r;
  logic [CONF_W-1:0] q_r;
  logic              ge;

  // compare against the shifted divisor
  always_comb begin
    shd = NW'(dv_i) << K;
    ge  = rem_i >= shd;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= ge ? rem_i - shd : rem_i;
      dv_r  <= dv_i;
      q_r   <= q_i | (CONF_W'(ge) << K);
    end
  end

  assign rem_o = rem_r;
  assign dv_o  = dv_r;
  assign q_o   = q_r;

endmodule
`default_nettype wire

### hw/rtl/tilt_compensated_heading.sv
// tilt compensated compass heading with confidence, top level
// depends on thc_pkg, thc_delay, thc_cordic_cell, thc_sqrt_cell and thc_div_cell
`default_nettype none
// One magnetometer sample plus attitude quaternion per beat in, one heading and
// confidence beat out. The datapath is fully pipelined and takes a new beat every
// cycle while the output side accepts; its depth is set by the square root chain
// (FIELD_BITS + 5 cells) followed by the 13 cell divider chain. The heading path
// (rotation, CORDIC_STAGES cordic cells) runs in parallel and is delay matched.
// A stall on the output freezes the whole pipe.
// Configuration registers are read live and must only change while idle.
module tilt_compensated_heading import thc_pkg::*; #(
  parameter int FIELD_BITS    = THC_FIELD_BITS,
  parameter int CORDIC_STAGES = THC_CORDIC_STAGES
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // field_x, field_y, field_z, quat_w, quat_x, quat_y, quat_z (16 bits each)
  input  wire logic [111:0] in_tdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // heading [15:0], confidence [28:16], zero pad
  output logic      [31:0]  out_tdata,
  // valid_res
  output logic      [0:0]   out_tuser,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [15:0]  cfg_wdata
);

  localparam int FB   = FIELD_BITS;
  localparam int CS   = CORDIC_STAGES;
  localparam int RW   = 34;
  localparam int PW   = RW + FB;
  localparam int NEW  = FB + 22;
  localparam int CW   = NEW + 2;
  localparam int ZW   = 34;
  localparam int SQN  = FB + 5;
  localparam int SQW  = 2 * SQN;
  localparam int RMW  = FB + 7;
  localparam int SW   = 2 * FB + 1;
  localparam int VW   = 2 * FB + 6;
  localparam int DVW  = (FB + 5 > 20) ? FB + 5 : 20;
  localparam int NW   = DVW + 13;
  localparam int RSW  = (FB + 1 > 22) ? FB + 1 : 22;
  localparam int LAT  = FB + 23;
  localparam int HDLY = FB + 17 - CS;

  localparam logic signed [RSW-1:0] CMAX = RSW'((64'sd1 <<< (FB - 1)) - 64'sd1);
  localparam logic signed [RSW-1:0] CMIN = -CMAX - RSW'(1);
  localparam logic signed [PW+1:0]  RND14 = (PW+2)'(8192);

  // ---------------- configuration registers
  logic signed [15:0] bias_r [3];
  logic        [15:0] scale_r [3];
  logic        [15:0] expected_r;
  logic signed [15:0] decl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        bias_r[a]  <= '0;
        scale_r[a] <= 16'(ONE_Q12);
      end
      expected_r <= 16'(ONE_Q12);
      decl_r     <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_addr))
        REG_BIAS_X:   bias_r[0]  <= cfg_wdata;
        REG_BIAS_Y:   bias_r[1]  <= cfg_wdata;
        REG_BIAS_Z:   bias_r[2]  <= cfg_wdata;
        REG_SCALE_X:  scale_r[0] <= cfg_wdata;
        REG_SCALE_Y:  scale_r[1] <= cfg_wdata;
        REG_SCALE_Z:  scale_r[2] <= cfg_wdata;
        REG_EXPECTED: expected_r <= cfg_wdata;
        REG_DECL:     decl_r     <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // ---------------- pipeline advance and valid line
  logic           en;
  logic [LAT-1:0] vld_r;

  assign en        = !vld_r[LAT-1] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_tvalid};
    end
  end

  // ---------------- stage 1: calibration and quaternion products
  logic signed [15:0]   fld [3];
  logic signed [15:0]   qw, qx, qy, qz;
  logic signed [FB-1:0] c_nxt [3];
  logic signed [FB-1:0] c1_r [3];
  logic                 zero_nxt, zero1_r;
  logic signed [31:0]   ww_r, xx_r, yy_r, zz_r, xy_r, wz_r, xz_r, wy_r, yz_r, wx_r;

  assign fld[0] = in_tdata[15:0];
  assign fld[1] = in_tdata[31:16];
  assign fld[2] = in_tdata[47:32];
  assign qw     = in_tdata[63:48];
  assign qx     = in_tdata[79:64];
  assign qy     = in_tdata[95:80];
  assign qz     = in_tdata[111:96];
  assign zero_nxt = (fld[0] == '0) && (fld[1] == '0) && (fld[2] == '0);

  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic signed [16:0]    d;
    logic signed [33:0]    p;
    logic signed [RSW-1:0] rs;
    // remove hard iron, scale soft iron, round and saturate
    assign d  = 17'(fld[a]) - 17'(bias_r[a]);
    assign p  = d * $signed({1'b0, scale_r[a]});
    assign rs = RSW'((p + 34'sd2048) >>> 12);
    assign c_nxt[a] = (rs > CMAX) ? FB'(CMAX) : ((rs < CMIN) ? FB'(CMIN) : FB'(rs));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zero1_r <= zero_nxt;
      c1_r    <= c_nxt;
      ww_r    <= qw * qw;
      xx_r    <= qx * qx;
      yy_r    <= qy * qy;
      zz_r    <= qz * qz;
      xy_r    <= qx * qy;
      wz_r    <= qw * qz;
      xz_r    <= qx * qz;
      wy_r    <= qw * qy;
      yz_r    <= qy * qz;
      wx_r    <= qw * qx;
    end
  end

  // ---------------- stage 2: rotation rows and field squares
  logic signed [RW-1:0] r00_r, r01_r, r02_r, r10_r, r11_r, r12_r;
  logic signed [FB-1:0] c2_r [3];
  logic        [2*FB-1:0] sq2_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      r00_r <= RW'(ww_r) + RW'(xx_r) - RW'(yy_r) - RW'(zz_r);
      r01_r <= (RW'(xy_r) - RW'(wz_r)) <<< 1;
      r02_r <= (RW'(xz_r) + RW'(wy_r)) <<< 1;
      r10_r <= (RW'(xy_r) + RW'(wz_r)) <<< 1;
      r11_r <= RW'(ww_r) - RW'(xx_r) + RW'(yy_r) - RW'(zz_r);
      r12_r <= (RW'(yz_r) - RW'(wx_r)) <<< 1;
      c2_r  <= c1_r;
      for (int a = 0; a < 3; a++) begin
        sq2_r[a] <= (2*FB)'(c1_r[a] * c1_r[a]);
      end
    end
  end

  // ---------------- stage 3: rotation products, magnitude square, vertical test
  logic signed [PW-1:0] pn0_r, pn1_r, pn2_r, pe0_r, pe1_r, pe2_r;
  logic        [SW-1:0] s3_r;
  logic        [SW-1:0] s_sum;
  logic        [VW-1:0] vl, vr;
  logic                 vert3_r;
  logic        [FB-1:0] az3_r;

  always_comb begin
    s_sum = SW'(sq2_r[0]) + SW'(sq2_r[1]) + SW'(sq2_r[2]);
    vl    = (VW'(sq2_r[2]) << 4) + (VW'(sq2_r[2]) << 3) + VW'(sq2_r[2]);
    vr    = VW'(s_sum) << 4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pn0_r   <= PW'(r00_r) * PW'(c2_r[0]);
      pn1_r   <= PW'(r01_r) * PW'(c2_r[1]);
      pn2_r   <= PW'(r02_r) * PW'(c2_r[2]);
      pe0_r   <= PW'(r10_r) * PW'(c2_r[0]);
      pe1_r   <= PW'(r11_r) * PW'(c2_r[1]);
      pe2_r   <= PW'(r12_r) * PW'(c2_r[2]);
      s3_r    <= s_sum;
      vert3_r <= vl > vr;
      az3_r   <= c2_r[2][FB-1] ? FB'(-c2_r[2]) : FB'(c2_r[2]);
    end
  end

  // ---------------- stage 4: north and east
  logic signed [PW+1:0] sum_n, sum_e;
  logic signed [NEW-1:0] n4_r, e4_r;

  assign sum_n = (PW+2)'(pn0_r) + (PW+2)'(pn1_r) + (PW+2)'(pn2_r) + RND14;
  assign sum_e = (PW+2)'(pe0_r) + (PW+2)'(pe1_r) + (PW+2)'(pe2_r) + RND14;

  always_ff @(posedge clk) begin
    if (en) begin
      n4_r <= NEW'(sum_n >>> 14);
      e4_r <= NEW'(sum_e >>> 14);
    end
  end

  // ---------------- stage 5: half plane fold, then the cordic chain
  logic signed [CW-1:0] cx [CS+1];
  logic signed [CW-1:0] cy [CS+1];
  logic signed [ZW-1:0] cz [CS+1];
  logic signed [CW-1:0] x5_r, y5_r;
  logic signed [ZW-1:0] z5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (n4_r[NEW-1]) begin
        x5_r <= -CW'(n4_r);
        y5_r <= -CW'(e4_r);
        z5_r <= e4_r[NEW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        x5_r <= CW'(n4_r);
        y5_r <= CW'(e4_r);
        z5_r <= '0;
      end
    end
  end

  assign cx[0] = x5_r;
  assign cy[0] = y5_r;
  assign cz[0] = z5_r;

  for (genvar i = 0; i < CS; i++) begin : g_cordic
    thc_cordic_cell #(.CW(CW), .ZW(ZW), .IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .x_i (cx[i]),
      .y_i (cy[i]),
      .z_i (cz[i]),
      .x_o (cx[i+1]),
      .y_o (cy[i+1]),
      .z_o (cz[i+1])
    );
  end

  // ---------------- heading: round, add declination, wrap, clamp
  logic signed [ZW-1:0] z_rnd;
  logic signed [16:0]   zq;
  logic signed [18:0]   hs, hw;
  logic signed [15:0]   hd, hd_d;

  always_comb begin
    z_rnd = (cz[CS] + ZW'(65536)) >>> 17;
    zq    = 17'(z_rnd);
    hs    = 19'(zq) + 19'(decl_r);
    hw    = hs;
    if (hs > 19'(PI_Q13)) begin
      hw = hs - 19'(TWO_PI_Q13);
    end else if (hs < -19'(PI_Q13)) begin
      hw = hs + 19'(TWO_PI_Q13);
    end
    if (hw > 19'(PI_Q13)) begin
      hd = 16'(PI_Q13);
    end else if (hw < -19'(PI_Q13)) begin
      hd = -16'(PI_Q13);
    end else begin
      hd = 16'(hw);
    end
  end

  thc_delay #(.W(16), .N(HDLY)) u_hd_dly (
    .clk (clk), .en (en), .d_i (hd), .q_o (hd_d)
  );

  // ---------------- magnitude: square root chain
  logic [SQW-1:0] sq_rad  [SQN+1];
  logic [RMW-1:0] sq_rem  [SQN+1];
  logic [SQN-1:0] sq_root [SQN+1];

  assign sq_rad[0]  = SQW'(s3_r) << 8;
  assign sq_rem[0]  = '0;
  assign sq_root[0] = '0;

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    thc_sqrt_cell #(.SQW(SQW), .RMW(RMW), .RTW(SQN)) u_cell (
      .clk    (clk),
      .en     (en),
      .rad_i  (sq_rad[k]),
      .rem_i  (sq_rem[k]),
      .root_i (sq_root[k]),
      .rad_o  (sq_rad[k+1]),
      .rem_o  (sq_rem[k+1]),
      .root_o (sq_root[k+1])
    );
  end

  // vertical flag and |z| ride alongside the root chain
  logic [FB:0] vaz_d;

  thc_delay #(.W(FB+1), .N(SQN)) u_vaz_dly (
    .clk (clk), .en (en), .d_i ({vert3_r, az3_r}), .q_o (vaz_d)
  );

  // ---------------- deviation and vertical ratio setup
  logic [SQN-1:0] m4;
  logic [19:0]    e16;
  logic [DVW:0]   m4x, e16x, diff;
  logic           big_dev;
  logic [NW-1:0]  num1_r, num2_r;
  logic [DVW-1:0] dv1_r, dv2_r;
  conf_flags_t    flg_r, flg_d;

  always_comb begin
    m4      = sq_root[SQN];
    e16     = (expected_r == '0) ? 20'd16 : {expected_r, 4'd0};
    m4x     = (DVW+1)'(m4);
    e16x    = (DVW+1)'(e16);
    diff    = (m4x > e16x) ? m4x - e16x : e16x - m4x;
    big_dev = diff >= e16x;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num1_r        <= big_dev ? '0 : (NW'(diff) << 12) + NW'(e16 >> 1);
      dv1_r         <= DVW'(e16);
      num2_r        <= (NW'(vaz_d[FB-1:0]) << 16) + NW'(m4 >> 1);
      dv2_r         <= (m4 == '0) ? DVW'(1) : DVW'(m4);
      flg_r.m4_zero <= m4 == '0;
      flg_r.big_dev <= big_dev;
      flg_r.vert    <= vaz_d[FB];
    end
  end

  // ---------------- two divider chains
  logic [NW-1:0]     d1_rem [14];
  logic [DVW-1:0]    d1_dv  [14];
  logic [CONF_W-1:0] d1_q   [14];
  logic [NW-1:0]     d2_rem [14];
  logic [DVW-1:0]    d2_dv  [14];
  logic [CONF_W-1:0] d2_q   [14];

  assign d1_rem[0] = num1_r;
  assign d1_dv[0]  = dv1_r;
  assign d1_q[0]   = '0;
  assign d2_rem[0] = num2_r;
  assign d2_dv[0]  = dv2_r;
  assign d2_q[0]   = '0;

  for (genvar j = 0; j < 13; j++) begin : g_div
    thc_div_cell #(.NW(NW), .DVW(DVW), .K(12 - j)) u_dev (
      .clk (clk), .en (en),
      .rem_i (d1_rem[j]), .dv_i (d1_dv[j]), .q_i (d1_q[j]),
      .rem_o (d1_rem[j+1]), .dv_o (d1_dv[j+1]), .q_o (d1_q[j+1])
    );
    thc_div_cell #(.NW(NW), .DVW(DVW), .K(12 - j)) u_ratio (
      .clk (clk), .en (en),
      .rem_i (d2_rem[j]), .dv_i (d2_dv[j]), .q_i (d2_q[j]),
      .rem_o (d2_rem[j+1]), .dv_o (d2_dv[j+1]), .q_o (d2_q[j+1])
    );
  end

  thc_delay #(.W($bits(conf_flags_t)), .N(13)) u_flg_dly (
    .clk (clk), .en (en), .d_i (flg_r), .q_o (flg_d)
  );

  logic zero_d;

  thc_delay #(.W(1), .N(FB + 21)) u_zero_dly (
    .clk (clk), .en (en), .d_i (zero1_r), .q_o (zero_d)
  );

  // ---------------- final confidence and output register
  logic [CONF_W-1:0] c0, rq, one_m_r, conf;
  logic [2*CONF_W-1:0] cprod;

  always_comb begin
    c0      = CONF_W'(14'(ONE_Q12) - {1'b0, d1_q[13]});
    rq      = (d2_q[13] > CONF_W'(ONE_Q12)) ? CONF_W'(ONE_Q12) : d2_q[13];
    one_m_r = CONF_W'(ONE_Q12) - rq;
    cprod   = c0 * one_m_r;
    if (zero_d || flg_d.m4_zero || flg_d.big_dev) begin
      conf = '0;
    end else if (flg_d.vert) begin
      conf = CONF_W'((cprod + (2*CONF_W)'(HALF_Q12)) >> 12);
    end else begin
      conf = c0;
    end
  end

  logic [15:0]       head_r;
  logic [CONF_W-1:0] conf_r;
  logic              vres_r;

  always_ff @(posedge clk) begin
    if (en) begin
      head_r <= zero_d ? '0 : hd_d;
      conf_r <= conf;
      vres_r <= !zero_d;
    end
  end

  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {3'b000, conf_r, head_r};
  assign out_tuser  = vres_r;

  // ---------------- checks
  a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 32'd0)
    else $error("all zero sample must give zero heading and confidence");

  a_conf_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[28:16] <= 13'(ONE_Q12))
    else $error("confidence above unity");

  a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= 16'sd25736 &&
                    $signed(out_tdata[15:0]) >= -16'sd25736))
    else $error("heading outside plus or minus pi");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |=> $stable(vld_r))
    else $error("pipeline moved while stalled");

endmodule
`default_nettype wire

### tb/sv/tilt_compensated_heading_tb.sv
// self-checking testbench for the tilt compensated heading block
// depends on thc_pkg and tilt_compensated_heading; stream driver, checker, live predictor
`timescale 1ns / 100ps
module tilt_compensated_heading_tb;
  import thc_pkg::*;

  localparam int  LATENCY   = THC_FIELD_BITS + 23;
  localparam int  IDLE_MAX  = 4000;
  localparam longint PI_ANGLE = 64'sd3373259426;

  typedef struct {
    logic [111:0] data;
    int           gap;
  } sample_t;

  typedef struct {
    logic        valid_res;
    logic [15:0] heading;
    logic [12:0] confidence;
  } heading_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic [111:0] in_tdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [31:0]  out_tdata;
  logic [0:0]   out_tuser;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_addr = '0;
  logic [15:0]  cfg_wdata = '0;

  sample_t      pending_samples[$];
  heading_t     expected_headings[$];
  logic [15:0]  reg_shadow[8];
  logic         no_idle = 1'b0;
  int           gap_cnt = 0;
  int           stall_cnt = 0;
  int           idle_cycles = 0;
  int           mismatches = 0;
  int           beats_in = 0;
  int           beats_out = 0;
  int           zero_samples = 0;
  int           vertical_hits = 0;

  tilt_compensated_heading u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // heading and confidence of one sample, under the current register values
  function automatic heading_t compute_heading(logic [111:0] d);
    longint f[3], c[3], dd, qw, qx, qy, qz;
    longint r00, r01, r02, r10, r11, r12, n, e, x, y, z, xs, ys, hd;
    longint unsigned s, m4, e16, diff, conf, cz2, az, r, v, rt, bit_v;
    heading_t res;
    int k;
    for (k = 0; k < 3; k++) f[k] = longint'($signed(d[16*k +: 16]));
    res.valid_res = 1'b0;
    res.heading = '0;
    res.confidence = '0;
    if (f[0] == 0 && f[1] == 0 && f[2] == 0) return res;
    // hard and soft iron correction
    for (k = 0; k < 3; k++) begin
      dd = (f[k] - longint'($signed(reg_shadow[k]))) * longint'(reg_shadow[3 + k]);
      dd = (dd + 2048) >>> 12;
      c[k] = dd > 32767 ? 32767 : (dd < -32768 ? -32768 : dd);
    end
    // body to navigation rotation
    qw = longint'($signed(d[63:48]));
    qx = longint'($signed(d[79:64]));
    qy = longint'($signed(d[95:80]));
    qz = longint'($signed(d[111:96]));
    r00 = qw*qw + qx*qx - qy*qy - qz*qz;
    r01 = 2 * (qx*qy - qw*qz);
    r02 = 2 * (qx*qz + qw*qy);
    r10 = 2 * (qx*qy + qw*qz);
    r11 = qw*qw - qx*qx + qy*qy - qz*qz;
    r12 = 2 * (qy*qz - qw*qx);
    n = (r00*c[0] + r01*c[1] + r02*c[2] + 8192) >>> 14;
    e = (r10*c[0] + r11*c[1] + r12*c[2] + 8192) >>> 14;
    // cordic vectoring atan2(e, n)
    z = 0;
    x = n;
    y = e;
    if (!(x == 0 && y == 0)) begin
      if (x < 0) begin
        z = (y >= 0) ? PI_ANGLE : -PI_ANGLE;
        x = -x;
        y = -y;
      end
      for (k = 0; k < THC_CORDIC_STAGES && k < 24; k++) begin
        xs = x >>> k;
        ys = y >>> k;
        if (y > 0) begin
          x += ys; y -= xs; z += longint'(ATAN_Q30[k]);
        end else if (y < 0) begin
          x -= ys; y += xs; z -= longint'(ATAN_Q30[k]);
        end
      end
    end
    // declination and wrap into +-pi
    hd = ((z + 65536) >>> 17) + longint'($signed(reg_shadow[REG_DECL]));
    if (hd > PI_Q13) hd -= TWO_PI_Q13;
    else if (hd < -PI_Q13) hd += TWO_PI_Q13;
    if (hd > PI_Q13) hd = PI_Q13;
    if (hd < -PI_Q13) hd = -PI_Q13;
    // magnitude in 1/16 count by bitwise square root
    cz2 = longint'(c[2] * c[2]);
    s = longint'(c[0]*c[0]) + longint'(c[1]*c[1]) + cz2;
    v = s << 8;
    rt = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= rt + bit_v) begin
        v -= rt + bit_v;
        rt = (rt >> 1) + bit_v;
      end else begin
        rt >>= 1;
      end
      bit_v >>= 2;
    end
    m4 = rt;
    // confidence from field strength and vertical share
    if (m4 == 0) begin
      conf = 0;
    end else begin
      e16 = reg_shadow[REG_EXPECTED] == 0 ? 16 : longint'(reg_shadow[REG_EXPECTED]) * 16;
      diff = m4 > e16 ? m4 - e16 : e16 - m4;
      diff = (diff * 4096 + e16 / 2) / e16;
      conf = diff >= 4096 ? 0 : 4096 - diff;
      if (cz2 * 25 > s * 16) begin
        az = c[2] < 0 ? -c[2] : c[2];
        r = (az * 65536 + m4 / 2) / m4;
        if (r > 4096) r = 4096;
        conf = (conf * (4096 - r) + 2048) >> 12;
      end
      if (conf > 4096) conf = 4096;
    end
    res.valid_res = 1'b1;
    res.heading = hd[15:0];
    res.confidence = conf[12:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
    mismatches++;
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_headings.push_back(compute_heading(in_tdata));
        if (in_tdata[47:0] == '0) zero_samples++;
        beats_in++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_samples.size() > 0 && gap_cnt >= pending_samples[0].gap) begin
          in_tdata <= pending_samples[0].data;
          in_tvalid <= 1'b1;
          void'(pending_samples.pop_front());
          gap_cnt <= 0;
        end else begin
          in_tvalid <= 1'b0;
          if (pending_samples.size() > 0) gap_cnt <= gap_cnt + 1;
        end
      end
    end
  end

  // result checker and output backpressure
  always @(posedge clk) begin
    heading_t want;
    int stall_next;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_next = stall_cnt;
      if (out_tvalid && out_tready) begin
        if (expected_headings.size() == 0) begin
          report_mismatch("unexpected beat", beats_out, 0);
        end else begin
          want = expected_headings.pop_front();
          if (out_tuser[0] !== want.valid_res)
            report_mismatch("valid_res", out_tuser[0], want.valid_res);
          if (out_tdata[15:0] !== want.heading)
            report_mismatch("heading", $signed(out_tdata[15:0]), $signed(want.heading));
          if (out_tdata[28:16] !== want.confidence)
            report_mismatch("confidence", out_tdata[28:16], want.confidence);
          if (want.valid_res && want.confidence != 0 && want.confidence < 2048)
            vertical_hits++;
        end
        beats_out++;
        stall_next = no_idle ? 0 : $urandom_range(0, 6);
      end
      if (stall_next > 0) begin
        out_tready <= 1'b0;
        stall_cnt <= stall_next - 1;
      end else begin
        out_tready <= 1'b1;
        stall_cnt <= 0;
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("timeout: no beat for %0d cycles", IDLE_MAX);
      $display("** tilt_compensated_heading: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    reg_shadow[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] v[8]);
    int i;
    for (i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), v[i]);
  endtask

  task automatic add_sample(input int fx, input int fy, input int fz,
                            input int qw, input int qx, input int qy, input int qz);
    sample_t smp;
    smp.data = {qz[15:0], qy[15:0], qx[15:0], qw[15:0], fz[15:0], fy[15:0], fx[15:0]};
    smp.gap = (no_idle || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    pending_samples.push_back(smp);
  endtask

  function automatic int rand_quat_part();
    case ($urandom_range(0, 4))
      0: return -16384;
      1: return 16384;
      2: return 0;
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // mostly plausible samples near the expected strength, some noise and zeros
  task automatic add_random(input int count);
    int i, sel, span;
    for (i = 0; i < count; i++) begin
      sel = $urandom_range(0, 9);
      span = $urandom_range(0, 1) ? 4096 : 512;
      if (sel == 0)
        add_sample(int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768,
                   rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
      else if (sel == 1)
        add_sample(0, 0, 0, rand_quat_part(), rand_quat_part(), rand_quat_part(),
                   rand_quat_part());
      else
        add_sample(int'($urandom_range(0, 2*span)) - span,
                   int'($urandom_range(0, 2*span)) - span,
                   int'($urandom_range(0, 2*span)) - span,
                   rand_quat_part(), rand_quat_part(), rand_quat_part(), rand_quat_part());
    end
  endtask

  task automatic drain();
    while (pending_samples.size() > 0 || in_tvalid || expected_headings.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // stimulus sequence
  initial begin
    logic [15:0] regs_v[8];
    int i;
    reg_shadow = '{16'd0, 16'd0, 16'd0, 16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset registers, field and quaternion extremes, special cases
    add_sample(0, 0, 0, 16384, 0, 0, 0);
    add_sample(32767, 32767, 32767, 16384, 0, 0, 0);
    add_sample(-32768, -32768, -32768, 16384, 0, 0, 0);
    add_sample(4096, 0, 0, 16384, 16384, 16384, 16384);
    add_sample(0, 4096, 0, -16384, -16384, -16384, -16384);
    add_sample(0, 0, 500, 16384, 0, 0, 0);
    add_sample(-1000, 0, 0, 16384, 0, 0, 0);
    add_sample(-1000, -5, 0, 16384, 0, 0, 0);
    add_sample(3000, 3000, 1000, 0, 16384, 0, 0);
    add_sample(1000, 1000, 4000, 11585, 0, 11585, 0);
    add_sample(1, 0, 0, 0, 0, 0, 0);
    add_sample(-1, 1, -1, 16384, -16384, 16384, -16384);
    drain();

    // zero corrected field with maximal declination
    regs_v = '{16'd100, 16'd200, 16'd300, 16'd4096, 16'd4096, 16'd4096, 16'd0, 16'd25736};
    write_all(regs_v);
    add_sample(100, 200, 300, 16384, 0, 0, 0);
    add_sample(1000, 500, 300, 16384, 0, 0, 0);
    add_sample(-1000, 10, 300, 16384, 0, 0, 0);
    add_sample(-1000, -10, 300, 16384, 0, 0, 0);
    drain();

    // random at reset-like registers with idling
    regs_v = '{16'd0, 16'd0, 16'd0, 16'd4096, 16'd4096, 16'd4096, 16'd4096, 16'd0};
    write_all(regs_v);
    add_random(160);
    drain();

    // extremes: lowest biases, largest scales and strength, negative declination
    no_idle = 1'b1;
    regs_v = '{16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
               16'hA478};
    write_all(regs_v);
    add_random(160);
    drain();

    // extremes: highest biases, zero scales, unit strength
    no_idle = 1'b0;
    regs_v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd1, 16'd25736};
    write_all(regs_v);
    add_random(80);
    drain();

    // random register settings, plausible scales
    for (i = 0; i < 3; i++) begin
      no_idle = (i == 1);
      regs_v[0] = 16'(int'($urandom_range(0, 1023)) - 512);
      regs_v[1] = 16'(int'($urandom_range(0, 1023)) - 512);
      regs_v[2] = 16'(int'($urandom_range(0, 1023)) - 512);
      regs_v[3] = 16'($urandom_range(2048, 8192));
      regs_v[4] = 16'($urandom_range(2048, 8192));
      regs_v[5] = 16'($urandom_range(2048, 8192));
      regs_v[6] = (i == 2) ? 16'd0 : 16'($urandom_range(256, 6000));
      regs_v[7] = 16'(int'($urandom_range(0, 51472)) - 25736);
      write_all(regs_v);
      add_random(140);
      drain();
    end

    $display("covered %0d samples (%0d all-zero) over eight register settings", beats_in,
             zero_samples);
    $display("%0d results checked, %0d with reduced confidence", beats_out, vertical_hits);
    if (mismatches == 0 && expected_headings.size() == 0) begin
      $display("** tilt_compensated_heading: PASSED **");
    end else begin
      $display("** tilt_compensated_heading: FAILED **");
    end
    $finish;
  end

endmodule
